### rtl/clvm_pkg.sv
// shared types, constants and arithmetic step functions for the look-at view matrix block
`default_nettype none

package clvm_pkg;

	localparam int SQRT_STG = 16;
	localparam int DIV_STG  = 9;
	localparam int NORM_LAT = 5 + SQRT_STG + 1 + DIV_STG + 1;

	typedef logic [2:0][63:0] vec64_t;
	typedef logic [2:0][31:0] vec32_t;
	typedef logic [2:0][17:0] vec18_t;

	typedef struct packed {
		vec18_t right;
		vec18_t upward;
		vec18_t back;
		vec32_t shift;
	} res_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
		logic [63:0] x;
	} sq_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [47:0] num;
		logic [17:0] q;
	} dv_t;

	function automatic logic [5:0] msb_pos(input logic [63:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				p = 6'(i);
			end
		end
		return p;
	endfunction

	// one result bit of the digit-by-digit square root
	function automatic sq_t sqrt_step(input sq_t a);
		sq_t r;
		logic [35:0] rs;
		logic [35:0] tr;
		rs = {a.rem, a.x[63:62]};
		tr = {2'b00, a.root, 2'b01};
		if (rs >= tr) begin
			r.rem = 34'(rs - tr);
			r.root = {a.root[30:0], 1'b1};
		end else begin
			r.rem = rs[33:0];
			r.root = {a.root[30:0], 1'b0};
		end
		r.x = {a.x[61:0], 2'b00};
		return r;
	endfunction

	// one quotient bit of restoring division
	function automatic dv_t div_step(input dv_t a, input logic [31:0] n);
		dv_t r;
		logic [33:0] rs;
		rs = {a.rem[32:0], a.num[47]};
		if (rs >= {2'b00, n}) begin
			r.rem = rs - {2'b00, n};
			r.q = {a.q[16:0], 1'b1};
		end else begin
			r.rem = rs;
			r.q = {a.q[16:0], 1'b0};
		end
		r.num = {a.num[46:0], 1'b0};
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/clvm_norm.sv
// pipelined fixed-point 3-vector normalizer: scale, sum of squares, square root, divide
`default_nettype none

module clvm_norm (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_vld,
	input  wire clvm_pkg::vec64_t c,
	output logic                 out_vld,
	output clvm_pkg::vec18_t     o
);

	typedef struct packed {
		logic [2:0][30:0] mag;
		logic [2:0]       neg;
		logic             zero;
	} side_t;

	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s22, vld_s32;
	logic [2:0][63:0] mag_s1, mag_s2;
	logic [2:0]       neg_s1, neg_s2;
	logic [5:0]       pos_s2;
	logic             zero_s2;
	logic [63:0]      or_all;
	logic [5:0]       rsh, lsh;
	logic [2:0][30:0] sh_c;
	side_t            side_s3, side_s4, side_s5, side_s22;
	logic [2:0][61:0] sqr_s4;
	logic [63:0]      sum_s5;

	clvm_pkg::sq_t                 rt_in [clvm_pkg::SQRT_STG];
	clvm_pkg::sq_t                 rt_sn [clvm_pkg::SQRT_STG];
	side_t                         rts_sn [clvm_pkg::SQRT_STG];
	logic [clvm_pkg::SQRT_STG-1:0] rtv_sn;

	logic [31:0]      n_s22;
	logic [2:0][47:0] num_s22;

	clvm_pkg::dv_t                dv_in [clvm_pkg::DIV_STG][3];
	clvm_pkg::dv_t                dv_sn [clvm_pkg::DIV_STG][3];
	logic [31:0]                  dn_sn [clvm_pkg::DIV_STG];
	side_t                        dvs_sn [clvm_pkg::DIV_STG];
	logic [clvm_pkg::DIV_STG-1:0] dvv_sn;

	clvm_pkg::vec18_t o_s32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			rtv_sn <= '0;
			vld_s22 <= 1'b0;
			dvv_sn <= '0;
			vld_s32 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			rtv_sn <= {rtv_sn[clvm_pkg::SQRT_STG-2:0], vld_s5};
			vld_s22 <= rtv_sn[clvm_pkg::SQRT_STG-1];
			dvv_sn <= {dvv_sn[clvm_pkg::DIV_STG-2:0], vld_s22};
			vld_s32 <= dvv_sn[clvm_pkg::DIV_STG-1];
		end
	end

	assign or_all = mag_s1[0] | mag_s1[1] | mag_s1[2];

	// bring the largest magnitude into [2^30, 2^31)
	always_comb begin
		rsh = pos_s2 - 6'd30;
		lsh = 6'd30 - pos_s2;
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 >= 6'd31) begin
				sh_c[i] = 31'(mag_s2[i] >> rsh);
			end else begin
				sh_c[i] = 31'(mag_s2[i] << lsh);
			end
		end
	end

	always_comb begin
		rt_in[0].rem = '0;
		rt_in[0].root = '0;
		rt_in[0].x = sum_s5;
		for (int k = 1; k < clvm_pkg::SQRT_STG; k++) begin
			rt_in[k] = rt_sn[k-1];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv_in[0][i].rem = {4'd0, num_s22[i][47:18]};
			dv_in[0][i].num = {num_s22[i][17:0], 30'd0};
			dv_in[0][i].q = '0;
			for (int k = 1; k < clvm_pkg::DIV_STG; k++) begin
				dv_in[k][i] = dv_sn[k-1][i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= c[i][63];
				mag_s1[i] <= c[i][63] ? (64'd0 - c[i]) : c[i];
			end
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			pos_s2 <= clvm_pkg::msb_pos(or_all);
			zero_s2 <= (or_all == 64'd0);

			side_s3.mag <= sh_c;
			side_s3.neg <= neg_s2;
			side_s3.zero <= zero_s2;

			for (int i = 0; i < 3; i++) begin
				sqr_s4[i] <= side_s3.mag[i] * side_s3.mag[i];
			end
			side_s4 <= side_s3;

			sum_s5 <= {2'b00, sqr_s4[0]} + {2'b00, sqr_s4[1]} + {2'b00, sqr_s4[2]};
			side_s5 <= side_s4;

			// two root bits per stage
			for (int k = 0; k < clvm_pkg::SQRT_STG; k++) begin
				rt_sn[k] <= clvm_pkg::sqrt_step(clvm_pkg::sqrt_step(rt_in[k]));
			end
			rts_sn[0] <= side_s5;
			for (int k = 1; k < clvm_pkg::SQRT_STG; k++) begin
				rts_sn[k] <= rts_sn[k-1];
			end

			// rounded numerator: mag * 2^16 + n / 2
			n_s22 <= rt_sn[clvm_pkg::SQRT_STG-1].root;
			for (int i = 0; i < 3; i++) begin
				num_s22[i] <= {1'b0, rts_sn[clvm_pkg::SQRT_STG-1].mag[i], 16'd0}
					+ {17'd0, rt_sn[clvm_pkg::SQRT_STG-1].root[31:1]};
			end
			side_s22 <= rts_sn[clvm_pkg::SQRT_STG-1];

			// two quotient bits per stage, three lanes share the divisor
			for (int k = 0; k < clvm_pkg::DIV_STG; k++) begin
				for (int i = 0; i < 3; i++) begin
					dv_sn[k][i] <= clvm_pkg::div_step(
						clvm_pkg::div_step(dv_in[k][i], (k == 0) ? n_s22 : dn_sn[k-1]),
						(k == 0) ? n_s22 : dn_sn[k-1]);
				end
			end
			dn_sn[0] <= n_s22;
			dvs_sn[0] <= side_s22;
			for (int k = 1; k < clvm_pkg::DIV_STG; k++) begin
				dn_sn[k] <= dn_sn[k-1];
				dvs_sn[k] <= dvs_sn[k-1];
			end

			for (int i = 0; i < 3; i++) begin
				if (dvs_sn[clvm_pkg::DIV_STG-1].zero) begin
					o_s32[i] <= '0;
				end else if (dvs_sn[clvm_pkg::DIV_STG-1].neg[i]) begin
					o_s32[i] <= 18'd0 - dv_sn[clvm_pkg::DIV_STG-1][i].q;
				end else begin
					o_s32[i] <= dv_sn[clvm_pkg::DIV_STG-1][i].q;
				end
			end
		end
	end

	assign out_vld = vld_s32;
	assign o = o_s32;

endmodule

`default_nettype wire

### rtl/clvm_skid.sv
// two-entry output buffer that decouples the pipeline from the result stall
`default_nettype none

module clvm_skid (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire clvm_pkg::res_t din,
	output logic                room,
	output logic                out_vld,
	input  wire logic           out_stall,
	output clvm_pkg::res_t      dout
);

	clvm_pkg::res_t mem_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;
	logic           pop;

	assign out_vld = (cnt_q != 2'd0);
	assign pop = out_vld && !out_stall;
	assign room = (cnt_q != 2'd2);
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q != 2'd2)
		else $error("beat pushed into full output buffer");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("output buffer count missed a push");
	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		(!push && pop) |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("output buffer count missed a pop");
`endif

endmodule

`default_nettype wire

### rtl/camera_lookat_view_matrix.sv
// top level of the look-at view matrix pipeline
`default_nettype none

// Look-at view matrix: each beat carries eye, look and up in signed Q16.16 and yields one
// beat with the basis rows u (right), v (upward), w (back) in signed Q2.16 and the saturated
// translation column. One beat is accepted every cycle while the output side keeps up;
// from accept to out_valid a beat runs through three normalizer passes in
// series (w and the normalized up share the first pass), each 32 stages deep with 16 of
// them for the square root at two bits a stage and 9 for the divide, plus nine stages of
// dot, cross and translation arithmetic. A two-entry output buffer lets the pipeline keep
// running for a beat while a result waits; in_stall rises only when that buffer is full.
module camera_lookat_view_matrix (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] eye_x,
	input  wire logic signed [31:0] eye_y,
	input  wire logic signed [31:0] eye_z,
	input  wire logic signed [31:0] look_x,
	input  wire logic signed [31:0] look_y,
	input  wire logic signed [31:0] look_z,
	input  wire logic signed [31:0] up_x,
	input  wire logic signed [31:0] up_y,
	input  wire logic signed [31:0] up_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [17:0]      right_x,
	output logic signed [17:0]      right_y,
	output logic signed [17:0]      right_z,
	output logic signed [17:0]      upward_x,
	output logic signed [17:0]      upward_y,
	output logic signed [17:0]      upward_z,
	output logic signed [17:0]      back_x,
	output logic signed [17:0]      back_y,
	output logic signed [17:0]      back_z,
	output logic signed [31:0]      shift_x,
	output logic signed [31:0]      shift_y,
	output logic signed [31:0]      shift_z
);

	localparam logic [31:0] SHIFT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] SHIFT_MIN = 32'h8000_0000;

	typedef struct packed {
		clvm_pkg::vec18_t w;
		clvm_pkg::vec32_t eye;
	} sidec_t;

	typedef struct packed {
		clvm_pkg::vec18_t v;
		clvm_pkg::vec18_t w;
		clvm_pkg::vec32_t eye;
	} sided_t;

	logic en;
	logic room;

	clvm_pkg::vec32_t eye_in;
	clvm_pkg::vec64_t nlook_in, up_in;

	logic             vld_a, vld_a_up, vld_c, vld_d;
	clvm_pkg::vec18_t w_a, un_a, v_c, u_d;

	clvm_pkg::vec32_t eye_dl_q [clvm_pkg::NORM_LAT];
	sidec_t           sc_dl_q [clvm_pkg::NORM_LAT];
	sided_t           sd_dl_q [clvm_pkg::NORM_LAT];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	clvm_pkg::vec18_t w_s1, w_s2, w_s3, w_s4, un_s1, un_s2, un_s3;
	clvm_pkg::vec32_t eye_s1, eye_s2, eye_s3, eye_s4;
	logic [2:0][35:0] p_s1;
	logic [37:0]      d_s2;
	logic [2:0][55:0] dw_s3;
	clvm_pkg::vec64_t tmp_s4;

	sidec_t           sc_s5;
	clvm_pkg::vec18_t v_s5;
	logic [5:0][35:0] pvw_s5;
	sided_t           sd_s6;
	clvm_pkg::vec64_t cr_s6;

	logic [2:0][2:0][17:0] rows_d;
	logic [2:0][2:0][17:0] rows_s7, rows_s8, rows_s9;
	clvm_pkg::vec32_t      eye_d;
	logic [2:0][2:0][49:0] pe_s7;
	logic [2:0][51:0]      sum_s8;
	logic [2:0][31:0]      sh_c;
	clvm_pkg::vec32_t      sh_s9;

	clvm_pkg::res_t res_s9, res_out;

	assign en = room;
	assign in_stall = !en;

	assign eye_in = {eye_z, eye_y, eye_x};
	assign nlook_in[0] = 64'd0 - {{32{look_x[31]}}, look_x};
	assign nlook_in[1] = 64'd0 - {{32{look_y[31]}}, look_y};
	assign nlook_in[2] = 64'd0 - {{32{look_z[31]}}, look_z};
	assign up_in[0] = {{32{up_x[31]}}, up_x};
	assign up_in[1] = {{32{up_y[31]}}, up_y};
	assign up_in[2] = {{32{up_z[31]}}, up_z};

	clvm_norm u_norm_w (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(in_valid), .c(nlook_in),
		.out_vld(vld_a), .o(w_a)
	);

	clvm_norm u_norm_up (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(in_valid), .c(up_in),
		.out_vld(vld_a_up), .o(un_a)
	);

	clvm_norm u_norm_v (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s4), .c(tmp_s4),
		.out_vld(vld_c), .o(v_c)
	);

	clvm_norm u_norm_u (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s6), .c(cr_s6),
		.out_vld(vld_d), .o(u_d)
	);

	// side data follows each normalizer pass
	always_ff @(posedge clk) begin
		if (en) begin
			eye_dl_q[0] <= eye_in;
			sc_dl_q[0] <= '{w: w_s4, eye: eye_s4};
			sd_dl_q[0] <= sd_s6;
			for (int k = 1; k < clvm_pkg::NORM_LAT; k++) begin
				eye_dl_q[k] <= eye_dl_q[k-1];
				sc_dl_q[k] <= sc_dl_q[k-1];
				sd_dl_q[k] <= sd_dl_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_a && vld_a_up;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_c;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_d;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	assign rows_d[0] = u_d;
	assign rows_d[1] = sd_dl_q[clvm_pkg::NORM_LAT-1].v;
	assign rows_d[2] = sd_dl_q[clvm_pkg::NORM_LAT-1].w;
	assign eye_d = sd_dl_q[clvm_pkg::NORM_LAT-1].eye;

	// round half up, then saturate to 32 bits
	always_comb begin
		logic [52:0] t;
		logic [36:0] qq;
		for (int r = 0; r < 3; r++) begin
			t = 53'd32768 - {sum_s8[r][51], sum_s8[r]};
			qq = t[52:16];
			if (!qq[36] && (qq[35:31] != 5'd0)) begin
				sh_c[r] = SHIFT_MAX;
			end else if (qq[36] && (qq[35:31] != 5'h1f)) begin
				sh_c[r] = SHIFT_MIN;
			end else begin
				sh_c[r] = qq[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// up_n . w
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= $signed(un_a[i]) * $signed(w_a[i]);
			end
			w_s1 <= w_a;
			un_s1 <= un_a;
			eye_s1 <= eye_dl_q[clvm_pkg::NORM_LAT-1];

			d_s2 <= $signed(p_s1[0]) + $signed(p_s1[1]) + $signed(p_s1[2]);
			w_s2 <= w_s1;
			un_s2 <= un_s1;
			eye_s2 <= eye_s1;

			for (int i = 0; i < 3; i++) begin
				dw_s3[i] <= $signed(d_s2) * $signed(w_s2[i]);
			end
			w_s3 <= w_s2;
			un_s3 <= un_s2;
			eye_s3 <= eye_s2;

			// up_n * 2^32 - d * w
			for (int i = 0; i < 3; i++) begin
				tmp_s4[i] <= {{14{un_s3[i][17]}}, un_s3[i], 32'd0}
					- {{8{dw_s3[i][55]}}, dw_s3[i]};
			end
			w_s4 <= w_s3;
			eye_s4 <= eye_s3;

			// v x w
			sc_s5 <= sc_dl_q[clvm_pkg::NORM_LAT-1];
			v_s5 <= v_c;
			pvw_s5[0] <= $signed(v_c[1]) * $signed(sc_dl_q[clvm_pkg::NORM_LAT-1].w[2]);
			pvw_s5[1] <= $signed(v_c[2]) * $signed(sc_dl_q[clvm_pkg::NORM_LAT-1].w[1]);
			pvw_s5[2] <= $signed(v_c[2]) * $signed(sc_dl_q[clvm_pkg::NORM_LAT-1].w[0]);
			pvw_s5[3] <= $signed(v_c[0]) * $signed(sc_dl_q[clvm_pkg::NORM_LAT-1].w[2]);
			pvw_s5[4] <= $signed(v_c[0]) * $signed(sc_dl_q[clvm_pkg::NORM_LAT-1].w[1]);
			pvw_s5[5] <= $signed(v_c[1]) * $signed(sc_dl_q[clvm_pkg::NORM_LAT-1].w[0]);

			for (int i = 0; i < 3; i++) begin
				cr_s6[i] <= {{28{pvw_s5[2*i][35]}}, pvw_s5[2*i]}
					- {{28{pvw_s5[2*i+1][35]}}, pvw_s5[2*i+1]};
			end
			sd_s6.v <= v_s5;
			sd_s6.w <= sc_s5.w;
			sd_s6.eye <= sc_s5.eye;

			// row . eye for all three rows
			for (int r = 0; r < 3; r++) begin
				for (int i = 0; i < 3; i++) begin
					pe_s7[r][i] <= $signed(rows_d[r][i]) * $signed(eye_d[i]);
				end
			end
			rows_s7 <= rows_d;

			for (int r = 0; r < 3; r++) begin
				sum_s8[r] <= {{2{pe_s7[r][0][49]}}, pe_s7[r][0]}
					+ {{2{pe_s7[r][1][49]}}, pe_s7[r][1]}
					+ {{2{pe_s7[r][2][49]}}, pe_s7[r][2]};
			end
			rows_s8 <= rows_s7;

			sh_s9 <= sh_c;
			rows_s9 <= rows_s8;
		end
	end

	assign res_s9.right = rows_s9[0];
	assign res_s9.upward = rows_s9[1];
	assign res_s9.back = rows_s9[2];
	assign res_s9.shift = sh_s9;

	clvm_skid u_skid (
		.clk(clk), .arst_n(arst_n), .push(vld_s9 && en), .din(res_s9), .room(room),
		.out_vld(out_valid), .out_stall(out_stall), .dout(res_out)
	);

	assign right_x = res_out.right[0];
	assign right_y = res_out.right[1];
	assign right_z = res_out.right[2];
	assign upward_x = res_out.upward[0];
	assign upward_y = res_out.upward[1];
	assign upward_z = res_out.upward[2];
	assign back_x = res_out.back[0];
	assign back_y = res_out.back[1];
	assign back_z = res_out.back[2];
	assign shift_x = res_out.shift[0];
	assign shift_y = res_out.shift[1];
	assign shift_z = res_out.shift[2];

endmodule

`default_nettype wire

### test/camera_lookat_view_matrix_tb.sv
// self-checking testbench for the look-at view matrix pipeline
`timescale 1ns / 100ps

module camera_lookat_view_matrix_tb;

	localparam int NUM_RANDOM = 1300;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_SHOWN = 10;
	localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;

	typedef longint trip_t [3];

	typedef struct {
		logic signed [31:0] eye [3];
		logic signed [31:0] look [3];
		logic signed [31:0] up [3];
	} camera_t;

	// rows u, v, w then translation
	typedef struct {
		logic [17:0] basis [9];
		logic [31:0] shift [3];
	} view_t;

	class view_scoreboard;
		view_t expected_views [$];
		int errors;

		function automatic longint unsigned int_sqrt(input longint unsigned x);
			longint unsigned res;
			longint unsigned bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > x)
				bitv >>= 2;
			while (bitv != 0) begin
				if (x >= res + bitv) begin
					x -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function automatic void unit_vec(input trip_t c, output trip_t o);
			longint unsigned mag [3];
			bit neg [3];
			longint unsigned m, sq, n, q;
			m = 0;
			for (int i = 0; i < 3; i++) begin
				neg[i] = c[i] < 0;
				mag[i] = neg[i] ? longint'(0) - c[i] : c[i];
				if (mag[i] > m)
					m = mag[i];
			end
			if (m == 0) begin
				o = '{0, 0, 0};
				return;
			end
			while (m >= (64'd1 << 31)) begin
				m >>= 1;
				for (int i = 0; i < 3; i++)
					mag[i] >>= 1;
			end
			while (m < (64'd1 << 30)) begin
				m <<= 1;
				for (int i = 0; i < 3; i++)
					mag[i] <<= 1;
			end
			sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
			n = int_sqrt(sq);
			for (int i = 0; i < 3; i++) begin
				q = (mag[i] * 64'd65536 + n / 2) / n;
				o[i] = neg[i] ? -longint'(q) : longint'(q);
			end
		endfunction

		function automatic logic [31:0] translation(input trip_t row, input trip_t eye);
			longint s, t, q;
			s = -(row[0] * eye[0] + row[1] * eye[1] + row[2] * eye[2]);
			t = s + 32768;
			if (t >= 0)
				q = t / 65536;
			else
				q = -((-t + 65535) / 65536);
			if (q > 64'sd2147483647)
				q = 64'sd2147483647;
			if (q < -64'sd2147483648)
				q = -64'sd2147483648;
			return q[31:0];
		endfunction

		function automatic void note_camera(input camera_t cam);
			trip_t eye, neg_look, up, up_n, u, v, w, tmp;
			longint d;
			view_t res;
			for (int i = 0; i < 3; i++) begin
				eye[i] = cam.eye[i];
				neg_look[i] = -longint'(cam.look[i]);
				up[i] = cam.up[i];
			end
			unit_vec(neg_look, w);
			unit_vec(up, up_n);
			d = up_n[0] * w[0] + up_n[1] * w[1] + up_n[2] * w[2];
			for (int i = 0; i < 3; i++)
				tmp[i] = up_n[i] * (64'sd1 << 32) - d * w[i];
			unit_vec(tmp, v);
			tmp[0] = v[1] * w[2] - v[2] * w[1];
			tmp[1] = v[2] * w[0] - v[0] * w[2];
			tmp[2] = v[0] * w[1] - v[1] * w[0];
			unit_vec(tmp, u);
			for (int i = 0; i < 3; i++) begin
				res.basis[i] = u[i][17:0];
				res.basis[3 + i] = v[i][17:0];
				res.basis[6 + i] = w[i][17:0];
			end
			res.shift[0] = translation(u, eye);
			res.shift[1] = translation(v, eye);
			res.shift[2] = translation(w, eye);
			expected_views.push_back(res);
		endfunction

		function automatic void fail(input string what);
			errors++;
			if (errors <= MAX_SHOWN)
				$display("%0t: %s", $realtime, what);
		endfunction

		function automatic void check_view(input view_t got);
			view_t exp_v;
			if (expected_views.size() == 0) begin
				fail("result beat with no camera pending");
				return;
			end
			exp_v = expected_views.pop_front();
			for (int i = 0; i < 9; i++)
				if (got.basis[i] !== exp_v.basis[i])
					fail($sformatf("basis row %0d col %0d: expected %h got %h",
						i / 3, i % 3, exp_v.basis[i], got.basis[i]));
			for (int i = 0; i < 3; i++)
				if (got.shift[i] !== exp_v.shift[i])
					fail($sformatf("shift %0d: expected %h got %h",
						i, exp_v.shift[i], got.shift[i]));
		endfunction

		function automatic int pending();
			return expected_views.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] eye_x, eye_y, eye_z;
	logic signed [31:0] look_x, look_y, look_z;
	logic signed [31:0] up_x, up_y, up_z;
	logic out_valid;
	logic out_stall;
	logic signed [17:0] right_x, right_y, right_z;
	logic signed [17:0] upward_x, upward_y, upward_z;
	logic signed [17:0] back_x, back_y, back_z;
	logic signed [31:0] shift_x, shift_y, shift_z;

	view_scoreboard sb;
	int hold_req;
	int idle_cycles;
	view_t got;

	camera_lookat_view_matrix i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
		.look_x(look_x), .look_y(look_y), .look_z(look_z),
		.up_x(up_x), .up_y(up_y), .up_z(up_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.right_x(right_x), .right_y(right_y), .right_z(right_z),
		.upward_x(upward_x), .upward_y(upward_y), .upward_z(upward_z),
		.back_x(back_x), .back_y(back_y), .back_z(back_z),
		.shift_x(shift_x), .shift_y(shift_y), .shift_z(shift_z)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// one camera beat; payload held until accepted
	task automatic send_camera(input camera_t cam);
		@(negedge clk);
		{eye_x, eye_y, eye_z} <= {cam.eye[0], cam.eye[1], cam.eye[2]};
		{look_x, look_y, look_z} <= {cam.look[0], cam.look[1], cam.look[2]};
		{up_x, up_y, up_z} <= {cam.up[0], cam.up[1], cam.up[2]};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_camera(cam);
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	function automatic camera_t mk(input logic signed [31:0] ex, ey, ez, lx, ly, lz,
			ux, uy, uz);
		camera_t c;
		c.eye = '{ex, ey, ez};
		c.look = '{lx, ly, lz};
		c.up = '{ux, uy, uz};
		return c;
	endfunction

	function automatic logic signed [31:0] rnd_scaled();
		return $signed($urandom) >>> $urandom_range(0, 31);
	endfunction

	function automatic camera_t rnd_camera();
		camera_t c;
		int r;
		r = $urandom_range(0, 99);
		for (int i = 0; i < 3; i++) begin
			c.eye[i] = (r < 30) ? $signed($urandom) : rnd_scaled();
			c.look[i] = (r < 30) ? $signed($urandom) : rnd_scaled();
			c.up[i] = (r < 30) ? $signed($urandom) : rnd_scaled();
		end
		if (r >= 70 && r < 82) begin
			// up parallel or antiparallel to look
			for (int i = 0; i < 3; i++)
				c.up[i] = (r < 76) ? c.look[i] >>> $urandom_range(0, 3) : -c.look[i];
		end else if (r >= 82 && r < 88) begin
			c.look[$urandom_range(0, 2)] = 0;
			c.up[$urandom_range(0, 2)] = 0;
		end else if (r >= 88 && r < 92) begin
			if (r[0])
				c.look = '{0, 0, 0};
			else
				c.up = '{0, 0, 0};
		end
		return c;
	endfunction

	// receiver: random stalls, or a long hold-off on request
	initial begin
		int len;
		bit st;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (hold_req > 0) begin
				len = hold_req;
				hold_req = 0;
				st = 1'b1;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
					: $urandom_range(1, 6);
				st = ($urandom_range(0, 99) < 30);
				if ($urandom_range(0, 19) == 0)
					len = $urandom_range(8, 40);
			end
			repeat (len) begin
				@(negedge clk);
				out_stall <= st;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got.basis = '{right_x, right_y, right_z, upward_x, upward_y, upward_z,
				back_x, back_y, back_z};
			got.shift = '{shift_x, shift_y, shift_z};
			sb.check_view(got);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("camera_lookat_view_matrix_tb: errors");
			$finish;
		end
	end

	initial begin
		camera_t directed [$];
		sb = new();
		hold_req = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		{eye_x, eye_y, eye_z, look_x, look_y, look_z, up_x, up_y, up_z} = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed.push_back(mk(0, 0, 0, 0, 0, -ONE, 0, ONE, 0));
		directed.push_back(mk(ONE, 2 * ONE, 3 * ONE, 0, 0, -ONE, 0, ONE, 0));
		directed.push_back(mk(S_MAX, S_MAX, S_MAX, ONE, 0, 0, 0, 0, ONE));
		directed.push_back(mk(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, 0, S_MIN));
		directed.push_back(mk(S_MAX, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MAX, 0));
		directed.push_back(mk(S_MIN, S_MAX, S_MIN, -ONE, ONE, -ONE, ONE, ONE, ONE));
		// zero look
		directed.push_back(mk(ONE, ONE, ONE, 0, 0, 0, 0, ONE, 0));
		// zero up
		directed.push_back(mk(ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, 0));
		// up parallel and antiparallel to look
		directed.push_back(mk(0, 0, 0, ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE));
		directed.push_back(mk(0, 0, 0, ONE, 0, 0, -ONE, 0, 0));
		directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(-1, 1, -1, 1, 0, 0, 0, 1, 0));
		directed.push_back(mk(S_MAX, S_MAX, S_MAX, -1, -1, -1, S_MIN, 1, 0));
		directed.push_back(mk(32'sh0000_8000, -32'sh0000_8000, 1, 3, -5, 7, S_MAX, S_MIN, 1));
		directed.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		foreach (directed[i])
			send_camera(directed[i]);
		pause_sender(1);

		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n == 400) begin
				// long output hold-off while items keep coming
				hold_req = HOLD_CYCLES;
				repeat (200) send_camera(rnd_camera());
			end
			if (n == 900) begin
				pause_sender(1);
				while (sb.pending() != 0)
					@(posedge clk);
			end
			send_camera(rnd_camera());
			if (n % 300 < 40)
				continue;
			pause_sender(gap_len());
		end
		pause_sender(1);

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("camera_lookat_view_matrix_tb: clean");
		else
			$display("camera_lookat_view_matrix_tb: errors");
		$finish;
	end

endmodule
